// ===== hdl/sgld_pkg.sv =====
`default_nettype none

package sgld_pkg;

	// operation codes carried on tuser
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_LINE  = 2'd1;
	localparam logic [1:0] OP_SHIFT = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam int OP_W     = 2;
	localparam int COORD_W  = 12;             // input coordinate fields
	localparam int PT_W     = COORD_W + 1;    // walking point and differences
	localparam int SPAN_W   = COORD_W;        // absolute span of a line
	localparam int ERR_W    = SPAN_W + 1;     // error term stays below twice the major span
	localparam int FILL_W   = 8;
	localparam int CELLV_W  = 8;
	localparam int WCNT_W   = 9;
	localparam int IN_DW    = 80;
	localparam int OUT_DW   = 24;

	typedef logic signed [PT_W-1:0] pt_t;

	// result of one Bresenham error update
	typedef struct packed {
		logic [ERR_W-1:0] err_next;
		logic             minor_step;
	} step_res_t;

endpackage

`default_nettype wire

// ===== hdl/scrolling_grid_line_drawer.sv =====
// Read: the addressed cell is fetched from the grid RAM and returned, zero when off the grid.
// Draw line: one cell written per step until the end point or until the walk leaves the grid;
// one shared error-update unit steps it. Shift: one cell moved per cycle through the grid RAM;
// a zero shift moves nothing. Clear: every cell is zeroed, as by a shift of GRID_SIZE or more.
// One item is in work at a time. After reset the grid is zeroed by a pass over
// every cell during which no item is accepted.
`default_nettype none

module scrolling_grid_line_drawer #(
	parameter int GRID_SIZE = 128,
	parameter int CELL_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// x_start, y_start, x_end, y_end, shift_x, shift_y, fill_value
	input  wire logic [79:0] s_axis_tdata,
	// op
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// cell_value, cells_written, zero pad
	output logic [23:0]      m_axis_tdata
);

	localparam int AW    = $clog2(GRID_SIZE);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int MAW   = $clog2(DEPTH);
	localparam int CNT_W = $clog2(GRID_SIZE + 1);
	localparam int PW    = sgld_pkg::PT_W;
	localparam int CW    = sgld_pkg::COORD_W;
	localparam int SW    = sgld_pkg::SPAN_W;

	localparam logic signed [PW-1:0] GS_S     = PW'(GRID_SIZE);
	localparam logic signed [PW-1:0] GS_NEG_S = -PW'(GRID_SIZE);
	localparam logic [AW-1:0]        LAST_RC  = AW'(GRID_SIZE - 1);
	localparam logic [MAW-1:0]       LAST_A   = MAW'(DEPTH - 1);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_RD       = 4'd1;
	localparam logic [3:0] ST_RD_WAIT  = 4'd2;
	localparam logic [3:0] ST_SETUP    = 4'd3;
	localparam logic [3:0] ST_LINE     = 4'd4;
	localparam logic [3:0] ST_SH_CHK   = 4'd5;
	localparam logic [3:0] ST_SHIFT    = 4'd6;
	localparam logic [3:0] ST_SH_DRAIN = 4'd7;
	localparam logic [3:0] ST_CLEAR    = 4'd8;
	localparam logic [3:0] ST_FIN      = 4'd9;

	function automatic logic in_grid(input sgld_pkg::pt_t v);
		in_grid = (v >= PW'(0)) && (v < GS_S);
	endfunction

	function automatic logic [MAW-1:0] addr_of(input logic [AW-1:0] xx,
	                                           input logic [AW-1:0] yy);
		addr_of = MAW'(yy) * MAW'(GRID_SIZE) + MAW'(xx);
	endfunction

	logic [3:0]            state_q;
	logic                  init_q;
	logic                  m_valid_q;
	logic [7:0]            out_cell_q;
	logic [8:0]            out_cnt_q;

	logic [1:0]            op_q;
	logic [CW-1:0]         xs_q, ys_q, xe_q, ye_q, shx_q, shy_q;
	logic [CELL_BITS-1:0]  fill_q;

	sgld_pkg::pt_t         x_q, y_q;
	logic [SW-1:0]         maj_q, minr_q, rem_q;
	logic [sgld_pkg::ERR_W-1:0] err_q;
	logic                  xmajor_q, sx_neg_q, sy_neg_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [7:0]            cell_q;
	logic                  rd_ok_q;

	logic [AW-1:0]         r_q, c_q;
	logic [MAW-1:0]        clr_addr_q;
	logic                  vld_s1, src_ok_s1;
	logic [MAW-1:0]        dst_addr_s1;

	// shared error-update unit
	sgld_pkg::step_res_t   step;

	sgld_line_step u_step (
		.err  (err_q),
		.minr (minr_q),
		.maj  (maj_q),
		.res  (step)
	);

	// grid RAM port signals
	logic                  wr_en, rd_en;
	logic [MAW-1:0]        wr_addr, rd_addr;
	logic [CELL_BITS-1:0]  wr_data, rd_data;

	sgld_grid_ram #(
		.DEPTH (DEPTH),
		.AW    (MAW),
		.W     (CELL_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// combinational helpers
	logic                  accept;
	logic                  out_free;
	sgld_pkg::pt_t         rd_x, rd_y;
	sgld_pkg::pt_t         ddx, ddy;
	logic [SW-1:0]         adx, ady;
	sgld_pkg::pt_t         shx_e, shy_e;
	logic                  sh_big;
	logic [AW-1:0]         xi, yi;
	sgld_pkg::pt_t         ox, oy;
	logic                  src_ok;
	logic                  line_in;
	logic                  shift_last;
	logic [8:0]            cnt_sat;

	always_comb begin
		accept   = s_axis_tvalid && s_axis_tready;
		out_free = !m_valid_q || m_axis_tready;

		rd_x = PW'(signed'(xs_q));
		rd_y = PW'(signed'(ys_q));

		ddx = PW'(signed'(xe_q)) - PW'(signed'(xs_q));
		ddy = PW'(signed'(ye_q)) - PW'(signed'(ys_q));
		adx = ddx[PW-1] ? SW'(-ddx) : SW'(ddx);
		ady = ddy[PW-1] ? SW'(-ddy) : SW'(ddy);

		shx_e  = PW'(signed'(shx_q));
		shy_e  = PW'(signed'(shy_q));
		sh_big = (shx_e <= GS_NEG_S) || (shx_e >= GS_S) ||
		         (shy_e <= GS_NEG_S) || (shy_e >= GS_S);

		// walk destinations away from the direction of motion
		xi = (!shx_q[CW-1] && (shx_q != '0)) ? (LAST_RC - c_q) : c_q;
		yi = (!shy_q[CW-1] && (shy_q != '0)) ? (LAST_RC - r_q) : r_q;
		ox = PW'(xi) - shx_e;
		oy = PW'(yi) - shy_e;
		src_ok = in_grid(ox) && in_grid(oy);
		shift_last = (r_q == LAST_RC) && (c_q == LAST_RC);

		line_in = in_grid(x_q) && in_grid(y_q);

		if (32'(cnt_q) > 32'd511) begin
			cnt_sat = 9'd511;
		end else begin
			cnt_sat = 9'(cnt_q);
		end

		rd_en   = 1'b0;
		rd_addr = '0;
		if (state_q == ST_RD) begin
			rd_en   = in_grid(rd_x) && in_grid(rd_y);
			rd_addr = addr_of(xs_q[AW-1:0], ys_q[AW-1:0]);
		end else if (state_q == ST_SHIFT) begin
			rd_en   = src_ok;
			rd_addr = addr_of(ox[AW-1:0], oy[AW-1:0]);
		end

		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = dst_addr_s1;
			wr_data = src_ok_s1 ? rd_data : '0;
		end else if (state_q == ST_LINE && line_in) begin
			wr_en   = 1'b1;
			wr_addr = addr_of(x_q[AW-1:0], y_q[AW-1:0]);
			wr_data = fill_q;
		end else if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, out_cnt_q, out_cell_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			init_q     <= 1'b1;
			clr_addr_q <= '0;
			m_valid_q  <= 1'b0;
			vld_s1     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			vld_s1 <= (state_q == ST_SHIFT);
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= s_axis_tuser;
						xs_q   <= s_axis_tdata[11:0];
						ys_q   <= s_axis_tdata[23:12];
						xe_q   <= s_axis_tdata[35:24];
						ye_q   <= s_axis_tdata[47:36];
						shx_q  <= s_axis_tdata[59:48];
						shy_q  <= s_axis_tdata[71:60];
						fill_q <= CELL_BITS'(s_axis_tdata[79:72]);
						cnt_q  <= '0;
						cell_q <= '0;
						case (s_axis_tuser)
							sgld_pkg::OP_READ:  state_q <= ST_RD;
							sgld_pkg::OP_LINE:  state_q <= ST_SETUP;
							sgld_pkg::OP_SHIFT: state_q <= ST_SH_CHK;
							default: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
						endcase
					end
				end
				ST_RD: begin
					rd_ok_q <= in_grid(rd_x) && in_grid(rd_y);
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					cell_q  <= rd_ok_q ? 8'(rd_data) : 8'd0;
					state_q <= ST_FIN;
				end
				ST_SETUP: begin
					x_q      <= rd_x;
					y_q      <= rd_y;
					sx_neg_q <= ddx[PW-1];
					sy_neg_q <= ddy[PW-1];
					xmajor_q <= (adx >= ady);
					if (adx >= ady) begin
						maj_q  <= adx;
						minr_q <= ady;
						rem_q  <= adx;
						err_q  <= {1'b0, adx >> 1};
					end else begin
						maj_q  <= ady;
						minr_q <= adx;
						rem_q  <= ady;
						err_q  <= {1'b0, ady >> 1};
					end
					state_q <= ST_LINE;
				end
				ST_LINE: begin
					if (!line_in) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
						err_q <= step.err_next;
						// major axis moves every step, minor only on error overflow
						if (xmajor_q || step.minor_step) begin
							x_q <= sx_neg_q ? (x_q - PW'(1)) : (x_q + PW'(1));
						end
						if (!xmajor_q || step.minor_step) begin
							y_q <= sy_neg_q ? (y_q - PW'(1)) : (y_q + PW'(1));
						end
						if (rem_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							rem_q <= rem_q - SW'(1);
						end
					end
				end
				ST_SH_CHK: begin
					r_q <= '0;
					c_q <= '0;
					if (shx_q == '0 && shy_q == '0) begin
						state_q <= ST_FIN;
					end else if (sh_big) begin
						clr_addr_q <= '0;
						state_q    <= ST_CLEAR;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					dst_addr_s1 <= addr_of(xi, yi);
					src_ok_s1   <= src_ok;
					if (c_q == LAST_RC) begin
						c_q <= '0;
						r_q <= r_q + AW'(1);
					end else begin
						c_q <= c_q + AW'(1);
					end
					if (shift_last) begin
						state_q <= ST_SH_DRAIN;
					end
				end
				ST_SH_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + MAW'(1);
					if (clr_addr_q == LAST_A) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_cell_q <= cell_q;
						out_cnt_q  <= cnt_sat;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// grid is never written while waiting for an item
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("grid write while idle");

	// error term stays below the major span during the walk
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINE && maj_q != '0) |-> (err_q < {1'b0, maj_q}))
		else $error("line error term out of range");

	// a line never writes more cells than one grid side
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) <= 32'(GRID_SIZE)))
		else $error("line count exceeds grid size");

	// only a draw line reports a write count
	a_cnt_only_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && op_q != sgld_pkg::OP_LINE) |-> (cnt_q == '0))
		else $error("write count on non-line op");

	// shift write stage follows a shift issue cycle
	a_shift_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |=> vld_s1)
		else $error("shift write stage lost");

endmodule

`default_nettype wire

// ===== hdl/sgld_grid_ram.sv =====
`default_nettype none

module sgld_grid_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int W     = 8
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [W-1:0]  wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/sgld_line_step.sv =====
`default_nettype none

module sgld_line_step (
	input  wire logic [sgld_pkg::ERR_W-1:0]  err,
	input  wire logic [sgld_pkg::SPAN_W-1:0] minr,
	input  wire logic [sgld_pkg::SPAN_W-1:0] maj,
	output sgld_pkg::step_res_t              res
);

	logic [sgld_pkg::ERR_W-1:0] sum;
	logic [sgld_pkg::ERR_W-1:0] maj_ext;

	always_comb begin
		maj_ext = {1'b0, maj};
		sum     = err + {1'b0, minr};
		if (sum >= maj_ext) begin
			res.err_next   = sum - maj_ext;
			res.minor_step = 1'b1;
		end else begin
			res.err_next   = sum;
			res.minor_step = 1'b0;
		end
	end

endmodule

`default_nettype wire
